### rtl/modexp_pkg.sv
// Shared constants, types and microcode program for the modular exponentiation block.
package modexp_pkg;

  localparam int MOD_WIDTH = 16;
  localparam int EXP_WIDTH = 16;
  localparam int DATA_W    = 16;
  localparam int OPW       = (MOD_WIDTH > DATA_W) ? MOD_WIDTH : DATA_W;
  localparam int PROD_W    = 2 * OPW;
  localparam int CNT_W     = $clog2(PROD_W);
  localparam int CFG_IDX_W = 1;
  localparam int UC_DEPTH  = 5;
  localparam int PC_W      = $clog2(UC_DEPTH);

  localparam logic [DATA_W-1:0] EXP_MASK =
    (EXP_WIDTH >= DATA_W) ? {DATA_W{1'b1}} : DATA_W'((64'd1 << EXP_WIDTH) - 64'd1);
  localparam logic [DATA_W-1:0] MOD_MASK =
    (MOD_WIDTH >= DATA_W) ? {DATA_W{1'b1}} : DATA_W'((64'd1 << MOD_WIDTH) - 64'd1);
  localparam logic [OPW-1:0] RES_MASK =
    (MOD_WIDTH >= OPW) ? {OPW{1'b1}} : OPW'((64'd1 << MOD_WIDTH) - 64'd1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POWER   = 1'b0,
    REG_MODULUS = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_MULACC,
    OP_MULSQ,
    OP_EMIT
  } uc_op_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_E_ZERO,
    COND_E_EVEN
  } uc_cond_t;

  typedef struct packed {
    uc_op_t            op;
    uc_cond_t          cond;
    logic [PC_W-1:0]   target;
  } ucode_t;

  typedef enum logic [1:0] {
    MM_IDLE,
    MM_MUL,
    MM_RED
  } mm_state_t;

  typedef struct packed {
    logic           start;
    logic [OPW-1:0] a;
    logic [OPW-1:0] b;
    logic [OPW-1:0] m;
  } mm_req_t;

  typedef struct packed {
    logic           done;
    logic [OPW-1:0] result;
  } mm_rsp_t;

  localparam logic [PC_W-1:0] STEP_TEST = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_BIT  = PC_W'(1);
  localparam logic [PC_W-1:0] STEP_MUL  = PC_W'(2);
  localparam logic [PC_W-1:0] STEP_SQR  = PC_W'(3);
  localparam logic [PC_W-1:0] STEP_EMIT = PC_W'(4);

  function automatic ucode_t ucode_word(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      STEP_TEST: w = '{op: OP_NOP,    cond: COND_E_ZERO, target: STEP_EMIT};
      STEP_BIT:  w = '{op: OP_NOP,    cond: COND_E_EVEN, target: STEP_SQR};
      STEP_MUL:  w = '{op: OP_MULACC, cond: COND_NEVER,  target: STEP_TEST};
      STEP_SQR:  w = '{op: OP_MULSQ,  cond: COND_ALWAYS, target: STEP_TEST};
      STEP_EMIT: w = '{op: OP_EMIT,   cond: COND_ALWAYS, target: STEP_TEST};
      default:   w = '{op: OP_EMIT,   cond: COND_ALWAYS, target: STEP_TEST};
    endcase
    return w;
  endfunction

endpackage

### rtl/modexp_mulmod.sv
// Multiply-then-reduce unit: one product, then a radix-2 restoring remainder.
module modexp_mulmod import modexp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  mm_req_t req,
  output mm_rsp_t rsp
);

  mm_state_t        state_r, state_nxt;
  logic [OPW-1:0]   a_r, b_r, m_r;
  logic [PROD_W-1:0] prod_r;
  logic [OPW-1:0]   rem_r;
  logic [CNT_W-1:0] cnt_r;

  logic [OPW:0]     trial;
  logic             ge;
  logic [OPW-1:0]   rem_nxt;

  always_comb begin
    trial   = {rem_r, prod_r[PROD_W-1]};
    ge      = trial >= {1'b0, m_r};
    rem_nxt = ge ? OPW'(trial - {1'b0, m_r}) : trial[OPW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MM_IDLE: if (req.start) begin
        state_nxt = MM_MUL;
      end
      MM_MUL:  state_nxt = MM_RED;
      MM_RED:  if (cnt_r == '0) begin
        state_nxt = MM_IDLE;
      end
      default: state_nxt = MM_IDLE;
    endcase
  end

  always_comb begin
    rsp.done   = (state_r == MM_RED) && (cnt_r == '0);
    rsp.result = rem_nxt & RES_MASK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      MM_IDLE: if (req.start) begin
        a_r <= req.a;
        b_r <= req.b;
        m_r <= req.m;
      end
      MM_MUL: begin
        prod_r <= PROD_W'(a_r) * PROD_W'(b_r);
        rem_r  <= '0;
        cnt_r  <= CNT_W'(PROD_W - 1);
      end
      MM_RED: begin
        prod_r <= prod_r << 1;
        rem_r  <= rem_nxt;
        cnt_r  <= cnt_r - CNT_W'(1);
      end
      default: ;
    endcase
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == MM_IDLE)
    else $error("multiply started while unit busy");

  a_mul_to_red: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == MM_MUL |=> state_r == MM_RED && cnt_r == CNT_W'(PROD_W - 1))
    else $error("reduction did not start after product");

  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp.done && m_r != '0) |-> rsp.result < m_r)
    else $error("remainder not below modulus");

endmodule

### rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block: config, microcode sequencer, datapath.
// Each base word returns base ** power mod modulus_value (1 when power is zero, unreduced),
// scanning the exponent from its least significant bit with square-and-multiply. A small
// microcode program steps the datapath; each modular multiplication goes through one shared
// multiply/reduce unit, which is launched, forms the product and then reduces it one product
// bit at a time with a restoring remainder. One item is worked at a time; the next base word
// is taken as soon as the result moves to the output register, even while that result still
// waits. A modulus of zero wraps products to their low bits. Configuration writes take effect
// at once and belong between items.
module modular_exponentiation import modexp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DATA_W-1:0]    in_base_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    out_residue
);

  logic [DATA_W-1:0] power_r, modulus_r;
  logic [OPW-1:0]    acc_r, b_r;
  logic [DATA_W-1:0] e_r;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic              busy_r, busy_nxt;
  logic              launched_r, launched_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_residue_r;

  ucode_t  cw;
  logic    cond_hit;
  logic    step_done;
  logic    in_fire;
  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  modexp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  assign in_ready    = !busy_r;
  assign in_fire     = in_valid && in_ready;
  assign out_valid   = out_valid_r;
  assign out_residue = out_residue_r;

  always_comb begin
    cw = ucode_word(pc_r);
    unique case (cw.cond)
      COND_NEVER:  cond_hit = 1'b0;
      COND_ALWAYS: cond_hit = 1'b1;
      COND_E_ZERO: cond_hit = (e_r == '0);
      COND_E_EVEN: cond_hit = !e_r[0];
      default:     cond_hit = 1'b0;
    endcase
    unique case (cw.op)
      OP_NOP:              step_done = 1'b1;
      OP_MULACC, OP_MULSQ: step_done = mm_rsp.done;
      OP_EMIT:             step_done = !out_valid_r || out_ready;
      default:             step_done = 1'b0;
    endcase
    mm_req.start = busy_r && !launched_r && (cw.op == OP_MULACC || cw.op == OP_MULSQ);
    mm_req.a     = (cw.op == OP_MULACC) ? acc_r : b_r;
    mm_req.b     = b_r;
    mm_req.m     = OPW'(modulus_r);
  end

  always_comb begin
    pc_nxt        = pc_r;
    busy_nxt      = busy_r;
    launched_nxt  = launched_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (in_fire) begin
      pc_nxt   = STEP_TEST;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mm_req.start) begin
        launched_nxt = 1'b1;
      end
      if (step_done) begin
        launched_nxt = 1'b0;
        pc_nxt       = cond_hit ? cw.target : pc_r + PC_W'(1);
        if (cw.op == OP_EMIT) begin
          busy_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_TEST;
      busy_r      <= 1'b0;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
      power_r     <= '0;
      modulus_r   <= DATA_W'(1);
    end else begin
      pc_r        <= pc_nxt;
      busy_r      <= busy_nxt;
      launched_r  <= launched_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_POWER:   power_r   <= cfg_wdata & EXP_MASK;
          REG_MODULUS: modulus_r <= cfg_wdata & MOD_MASK;
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_r   <= OPW'(in_base_value);
      acc_r <= OPW'(1);
      e_r   <= power_r;
    end else if (busy_r && step_done) begin
      unique case (cw.op)
        OP_MULACC: acc_r <= mm_rsp.result;
        OP_MULSQ: begin
          b_r <= mm_rsp.result;
          e_r <= e_r >> 1;
        end
        OP_EMIT:   out_residue_r <= acc_r[DATA_W-1:0];
        default:   ;
      endcase
    end
  end

  a_done_launched: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.done |-> launched_r)
    else $error("multiply result without a launch");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> busy_r && pc_r == STEP_TEST)
    else $error("accepted word did not start program");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && pc_r == STEP_EMIT) |-> e_r == '0)
    else $error("result emitted before exponent exhausted");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r) && !busy_r)
    else $error("output raised outside emit step");

endmodule

### tb/tb_top.sv
// Testbench for modular_exponentiation: random and corner-case bases against a predictor.
module tb_top;
  import modexp_pkg::*;

  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int DRAIN_CYCLES = 1200;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [DATA_W-1:0]    in_base_value;
  logic                 out_valid;
  logic                 out_ready;
  logic [DATA_W-1:0]    out_residue;

  logic [DATA_W-1:0] cur_power;
  logic [DATA_W-1:0] cur_modulus;
  logic [DATA_W-1:0] pending_residues[$];
  bit                gaps_on;
  int                mismatches;
  int                cycle_count;

  modular_exponentiation uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_base_value (in_base_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_residue   (out_residue)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] reduce_mod(input logic [63:0] x, input logic [DATA_W-1:0] m);
    if (m == '0) return x & 64'(MOD_MASK);
    return x % 64'(m);
  endfunction

  function automatic logic [DATA_W-1:0] modexp_residue(input logic [DATA_W-1:0] base,
                                                       input logic [DATA_W-1:0] pw,
                                                       input logic [DATA_W-1:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] e;
    acc = 64'd1;
    sq  = 64'(base);
    e   = 64'(pw);
    for (int k = 0; k < EXP_WIDTH; k++) begin
      if (e == 64'd0) break;
      if (e[0]) acc = reduce_mod(acc * sq, m);
      sq = reduce_mod(sq * sq, m);
      e  = e >> 1;
    end
    return acc[DATA_W-1:0];
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_POWER:   cur_power   = value & EXP_MASK;
      REG_MODULUS: cur_modulus = value & MOD_MASK;
      default: ;
    endcase
  endtask

  task automatic send_base(input logic [DATA_W-1:0] base);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      @(negedge clk);
      in_valid      = 1'b0;
      in_base_value = DATA_W'($urandom);
      repeat ($urandom_range(0, 11)) @(negedge clk);
    end
    @(negedge clk);
    in_valid      = 1'b1;
    in_base_value = base;
    do @(posedge clk); while (!in_ready);
    pending_residues.insert(pending_residues.size(),
                            modexp_residue(base, cur_power, cur_modulus));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_residues.size() != 0) @(posedge clk);
  endtask

  task automatic setup(input logic [DATA_W-1:0] pw, input logic [DATA_W-1:0] m);
    drain_results();
    write_reg(REG_POWER, pw);
    write_reg(REG_MODULUS, m);
  endtask

  function automatic logic [DATA_W-1:0] pick_base();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return DATA_W'(1);
      3: return DATA_W'($urandom_range(0, int'(cur_modulus) - 1));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // zero power with unit modulus straight out of reset
  task automatic test_reset_values();
    send_base('0);
    send_base('1);
  endtask

  task automatic test_corner_cases();
    setup(16'd5, 16'd1);
    send_base(16'd7);
    send_base('1);
    setup(16'd1, 16'd7);
    send_base('1);
    send_base(16'd100);
    setup('1, '1);
    send_base('0);
    send_base(16'd1);
    send_base(16'd2);
    send_base(16'hFFFE);
    send_base('1);
    setup('0, 16'd65521);
    send_base(16'd12345);
    send_base('0);
    setup(16'h8000, 16'd65521);
    send_base(16'd3);
    send_base(16'hAAAA);
    setup('1, 16'd2);
    send_base(16'h5555);
    send_base(16'hAAAA);
    setup(16'd2, 16'hFFFF);
    send_base('1);
    send_base(16'h8001);
  endtask

  task automatic test_random_phases();
    logic [DATA_W-1:0] pw;
    logic [DATA_W-1:0] m;
    for (int ph = 0; ph < 20; ph++) begin
      case ($urandom_range(0, 5))
        0:       pw = DATA_W'($urandom);
        5:       pw = '0;
        default: pw = DATA_W'($urandom_range(1, 255));
      endcase
      case ($urandom_range(0, 5))
        0:       m = '1;
        1:       m = DATA_W'(1);
        2:       m = DATA_W'($urandom_range(2, 255));
        default: m = DATA_W'($urandom_range(1, 65535));
      endcase
      setup(pw, m);
      repeat (45) send_base(pick_base());
    end
  endtask

  task automatic test_back_to_back();
    setup(DATA_W'($urandom_range(1, 4095)), '1);
    gaps_on = 1'b0;
    repeat (60) send_base(pick_base());
    setup(16'd3, DATA_W'($urandom_range(1, 65535)));
    repeat (40) send_base(pick_base());
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_POWER;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_base_value = '0;
    out_ready     = 1'b0;
    cur_power     = '0;
    cur_modulus   = DATA_W'(1);
    gaps_on       = 1'b1;
    mismatches    = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_corner_cases();
    test_random_phases();
    test_back_to_back();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // stall the result side in bursts
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_residues.size() == 0) begin
        $display("%0t: unexpected residue word, expected none, got %0d", $time, out_residue);
        mismatches++;
      end else begin
        logic [DATA_W-1:0] want;
        want = pending_residues.pop_front();
        if (out_residue !== want) begin
          $display("%0t: residue mismatch, expected %0d, got %0d", $time, want, out_residue);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d residues outstanding", $time, pending_residues.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

### filelist.f
rtl/modexp_pkg.sv
rtl/modexp_mulmod.sv
rtl/modular_exponentiation.sv
tb/tb_top.sv
